// ===== rtl/nearest_palette_colour_quantizer_defines.svh =====
// Assertion helpers for the palette quantizer.
`ifndef NEAREST_PALETTE_COLOUR_QUANTIZER_DEFINES_SVH
`define NEAREST_PALETTE_COLOUR_QUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npq check failed");

// Next-cycle implication, disabled during reset.
`define NPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npq check failed");

`endif

// ===== rtl/npq_pkg.sv =====
`default_nettype none

package npq_pkg;

  localparam int PALETTE_ENTRIES_MAX = 16;
  localparam int TREE_LEAVES         = 16;
  localparam int COLOR_W             = 8;
  localparam int ENTRY_W             = 4;
  localparam int DIST_W              = 18;
  localparam int RGB_W               = 24;
  localparam int PAIR_W              = 48;
  localparam int CFG_INDEX_W         = 4;
  localparam int CODE_W              = 8;
  localparam int SQ_W                = 2 * COLOR_W;

  localparam logic [COLOR_W-1:0] OPAQUE_ALPHA     = 8'hFF;
  localparam logic [CODE_W-1:0]  TRANSPARENT_CODE = 8'h0F;
  localparam int                 ENTRY_SHIFT      = 4;
  localparam logic [DIST_W-1:0]  DIST_NONE        = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX         = 18'd195075;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [DIST_W-1:0]  sq_dist;
  } cand_t;

  // a is the lower-numbered candidate and wins ties.
  function automatic cand_t min_cand(cand_t a, cand_t b);
    return (b.sq_dist < a.sq_dist) ? b : a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nearest_palette_colour_quantizer.sv =====
// Nearest palette colour quantizer.
// Input channel (in_valid/in_ready) carries one RGBA pixel per transaction;
// output channel (out_valid/out_ready) carries the closest palette entry,
// its squared RGB distance, the packed pixel code and a transparent flag.
// The palette lives in pair registers written over the cfg channel
// (cfg_index selects the pair, cfg_data holds two 24-bit entries); writes
// to an index past the stored pairs are dropped. cfg_ready is always high.
// The pipeline registers, in order: absolute differences, squares, per-entry
// sum, the first two levels of the minimum tree, then the last two levels
// into the output register. All entries are compared in parallel lanes, so one
// pixel is taken every cycle while the output moves.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// as soon as the output register is full and not taken; nothing is lost.
// Reset clears the palette to zero and empties the pipeline.
`default_nettype none

`include "nearest_palette_colour_quantizer_defines.svh"

module nearest_palette_colour_quantizer #(
  parameter int PALETTE_ENTRIES = npq_pkg::PALETTE_ENTRIES_MAX
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [npq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [npq_pkg::PAIR_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [npq_pkg::COLOR_W-1:0]       red,
  input  wire logic [npq_pkg::COLOR_W-1:0]       green,
  input  wire logic [npq_pkg::COLOR_W-1:0]       blue,
  input  wire logic [npq_pkg::COLOR_W-1:0]       alpha,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [npq_pkg::ENTRY_W-1:0]       nearest_entry,
  output logic      [npq_pkg::DIST_W-1:0]        best_distance,
  output logic      [npq_pkg::CODE_W-1:0]        pixel_code,
  output logic                                   is_transparent
);
  import npq_pkg::*;

  localparam int PAIRS = (PALETTE_ENTRIES + 1) / 2;

  logic [PAIR_W-1:0] pair [PAIRS];
  logic              en;
  logic [3:0]        stage_valid;
  logic [3:0]        stage_transp;
  cand_t             leaf [TREE_LEAVES];
  cand_t             lvl1 [TREE_LEAVES/2];
  cand_t             lvl2 [TREE_LEAVES/4];
  cand_t             q4   [TREE_LEAVES/4];
  cand_t             m0, m1, best;

  assign cfg_ready = 1'b1;
  // advance everything unless a finished result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    for (int k = 0; k < PAIRS; k++) begin
      if (rst) begin
        pair[k] <= '0;
      end else if (cfg_valid && cfg_index == CFG_INDEX_W'(k)) begin
        pair[k] <= cfg_data;
      end
    end
  end

  for (genvar n = 0; n < TREE_LEAVES; n++) begin : g_lane
    if (n < PALETTE_ENTRIES) begin : g_used
      logic [DIST_W-1:0] lane_dist;
      npq_lane u_lane (
        .clk       (clk),
        .en        (en),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .entry_rgb (pair[n/2][(n%2)*RGB_W +: RGB_W]),
        .sq_dist   (lane_dist)
      );
      assign leaf[n] = '{entry: ENTRY_W'(n), sq_dist: lane_dist};
    end else begin : g_pad
      assign leaf[n] = '{entry: ENTRY_W'(n), sq_dist: DIST_NONE};
    end
  end

  always_comb begin
    for (int i = 0; i < TREE_LEAVES/2; i++) begin
      lvl1[i] = min_cand(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < TREE_LEAVES/4; i++) begin
      lvl2[i] = min_cand(lvl1[2*i], lvl1[2*i+1]);
    end
    m0   = min_cand(q4[0], q4[1]);
    m1   = min_cand(q4[2], q4[3]);
    best = min_cand(m0, m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (en) begin
      stage_valid <= {stage_valid[2:0], in_valid};
      out_valid   <= stage_valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_transp <= {stage_transp[2:0], alpha != OPAQUE_ALPHA};
      for (int i = 0; i < TREE_LEAVES/4; i++) begin
        q4[i] <= lvl2[i];
      end
      nearest_entry  <= best.entry;
      best_distance  <= best.sq_dist;
      is_transparent <= stage_transp[3];
      pixel_code     <= stage_transp[3] ? TRANSPARENT_CODE
                                        : (CODE_W'(best.entry) << ENTRY_SHIFT);
    end
  end

  `NPQ_ASSERT_NOW(a_code_transp, clk, rst, out_valid && is_transparent, pixel_code == TRANSPARENT_CODE)
  `NPQ_ASSERT_NOW(a_code_opaque, clk, rst, out_valid && !is_transparent, pixel_code == (CODE_W'(nearest_entry) << ENTRY_SHIFT))
  `NPQ_ASSERT_NOW(a_entry_range, clk, rst, out_valid, (32'(nearest_entry) < 32'(PALETTE_ENTRIES)) && (best_distance <= DIST_MAX))
  `NPQ_ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && in_ready, stage_valid[0])

endmodule

`default_nettype wire

// ===== rtl/npq_lane.sv =====
`default_nettype none

module npq_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [npq_pkg::COLOR_W-1:0]   red,
  input  wire logic [npq_pkg::COLOR_W-1:0]   green,
  input  wire logic [npq_pkg::COLOR_W-1:0]   blue,
  input  wire logic [npq_pkg::RGB_W-1:0]     entry_rgb,
  output logic      [npq_pkg::DIST_W-1:0]    sq_dist
);
  import npq_pkg::*;

  logic [COLOR_W-1:0] er, eg, eb;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]    sr, sg, sb;

  assign er = entry_rgb[23:16];
  assign eg = entry_rgb[15:8];
  assign eb = entry_rgb[7:0];

  // absolute differences, squares, sum: one register stage each
  always_ff @(posedge clk) begin
    if (en) begin
      dr      <= (red   >= er) ? (red   - er) : (er - red);
      dg      <= (green >= eg) ? (green - eg) : (eg - green);
      db      <= (blue  >= eb) ? (blue  - eb) : (eb - blue);
      sr      <= dr * dr;
      sg      <= dg * dg;
      sb      <= db * db;
      sq_dist <= DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_nearest_palette_colour_quantizer.sv =====
module tb_nearest_palette_colour_quantizer;
  import npq_pkg::*;

  localparam int PAIR_COUNT     = PALETTE_ENTRIES_MAX / 2;
  localparam int ACTIVE_ENTRIES = PALETTE_ENTRIES_MAX;
  localparam int LAST_INDEX     = (1 << CFG_INDEX_W) - 1;
  localparam int LATENCY        = 5;
  localparam int IDLE_PCT       = 7;
  localparam int HOLD_CYCLES    = 60;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [DIST_W-1:0]  sq_dist;
    logic [CODE_W-1:0]  code;
    logic               transparent;
  } match_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] a;
  } rgba_t;

  class palette_match_board;
    logic [PAIR_W-1:0] pairs [PAIR_COUNT];
    match_t            expected_matches [$];
    int                failures;

    function new();
      foreach (pairs[k]) pairs[k] = '0;
      failures = 0;
    endfunction

    // Indexes past the stored pairs are dropped by the block.
    function void set_pair(int unsigned idx, logic [PAIR_W-1:0] value);
      if (idx < PAIR_COUNT) pairs[idx] = value;
    endfunction

    function match_t nearest_match(rgba_t px);
      match_t            m;
      logic [RGB_W-1:0]  e;
      int                dr;
      int                dg;
      int                db;
      int                d;
      m = '0;
      for (int n = 0; n < ACTIVE_ENTRIES; n++) begin
        e  = pairs[n / 2][(n % 2) * RGB_W +: RGB_W];
        dr = int'(px.r) - int'(e[23:16]);
        dg = int'(px.g) - int'(e[15:8]);
        db = int'(px.b) - int'(e[7:0]);
        d  = dr * dr + dg * dg + db * db;
        // strict compare keeps the lowest entry on a tie
        if (n == 0 || d < int'(m.sq_dist)) begin
          m.entry   = ENTRY_W'(n);
          m.sq_dist = DIST_W'(d);
        end
      end
      m.transparent = (px.a != OPAQUE_ALPHA);
      m.code = m.transparent ? TRANSPARENT_CODE : (CODE_W'(m.entry) << ENTRY_SHIFT);
      return m;
    endfunction

    function void note_pixel(rgba_t px);
      expected_matches.insert(expected_matches.size(), nearest_match(px));
    endfunction

    function void check_result(match_t got);
      match_t want;
      if (expected_matches.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result with nothing pending: entry %0d dist %0d code %h transparent %0b",
                   got.entry, got.sq_dist, got.code, got.transparent);
        return;
      end
      want = expected_matches.pop_front();
      if (got.entry !== want.entry || got.sq_dist !== want.sq_dist ||
          got.code !== want.code || got.transparent !== want.transparent) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result mismatch: exp entry %0d dist %0d code %h transparent %0b, got entry %0d dist %0d code %h transparent %0b",
                   want.entry, want.sq_dist, want.code, want.transparent,
                   got.entry, got.sq_dist, got.code, got.transparent);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [PAIR_W-1:0]      cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [COLOR_W-1:0]     red;
  logic [COLOR_W-1:0]     green;
  logic [COLOR_W-1:0]     blue;
  logic [COLOR_W-1:0]     alpha;
  logic                   out_valid;
  logic                   out_ready;
  logic [ENTRY_W-1:0]     nearest_entry;
  logic [DIST_W-1:0]      best_distance;
  logic [CODE_W-1:0]      pixel_code;
  logic                   is_transparent;

  palette_match_board     board = new();
  logic [RGB_W-1:0]       palette [PALETTE_ENTRIES_MAX];
  bit                     steady;
  bit                     hold_req;
  int unsigned            cycle_count = 0;

  nearest_palette_colour_quantizer #(
    .PALETTE_ENTRIES(ACTIVE_ENTRIES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .nearest_entry (nearest_entry),
    .best_distance (best_distance),
    .pixel_code    (pixel_code),
    .is_transparent(is_transparent)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_pair(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_pixel({red, green, blue, alpha});
      if (out_valid && out_ready)
        board.check_result({nearest_entry, best_distance, pixel_code, is_transparent});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_nearest_palette_colour_quantizer NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COLOR_W'(v);
  endfunction

  function automatic logic [COLOR_W-1:0] corner_level();
    return $urandom_range(1) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [COLOR_W-1:0] halfway(logic [COLOR_W-1:0] x,
                                                 logic [COLOR_W-1:0] y);
    return COLOR_W'((9'(x) + 9'(y)) >> 1);
  endfunction

  function automatic rgba_t random_pixel();
    rgba_t       px;
    int unsigned mode;
    int unsigned i;
    int unsigned j;
    mode = $urandom_range(99);
    i    = $urandom_range(ACTIVE_ENTRIES - 1);
    j    = $urandom_range(ACTIVE_ENTRIES - 1);
    if (mode < 40) begin
      px.r = nudge(palette[i][23:16]);
      px.g = nudge(palette[i][15:8]);
      px.b = nudge(palette[i][7:0]);
    end else if (mode < 70) begin
      {px.r, px.g, px.b} = RGB_W'($urandom);
    end else if (mode < 85) begin
      px.r = corner_level();
      px.g = corner_level();
      px.b = corner_level();
    end else begin
      // midway between two entries: frequent exact ties
      px.r = halfway(palette[i][23:16], palette[j][23:16]);
      px.g = halfway(palette[i][15:8], palette[j][15:8]);
      px.b = halfway(palette[i][7:0], palette[j][7:0]);
    end
    px.a = ($urandom_range(99) < 80) ? OPAQUE_ALPHA : COLOR_W'($urandom);
    return px;
  endfunction

  task automatic send_pixel(input rgba_t px);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {red, green, blue, alpha} <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [PAIR_W-1:0] value);
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input until every pending result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_matches.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all pairs, then junk to the unused indexes, which must not alias.
  task automatic load_palette(input logic [PAIR_W-1:0] stray);
    drain();
    for (int k = 0; k < PAIR_COUNT; k++) write_reg(k, {palette[2 * k + 1], palette[2 * k]});
    for (int k = PAIR_COUNT; k <= LAST_INDEX; k++) write_reg(k, stray);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    red       = '0;
    green     = '0;
    blue      = '0;
    alpha     = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    foreach (palette[n]) palette[n] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // palette still at reset: everything ties on entry 0
    send_pixel(32'h000000FF);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'hFF00FF00);
    send_pixel(32'h123456FE);

    // cube corners, gray ramp, last entry duplicates entry 3
    foreach (palette[n]) begin
      if (n < 8)
        palette[n] = {n[2] ? 8'hFF : 8'h00, n[1] ? 8'hFF : 8'h00, n[0] ? 8'hFF : 8'h00};
      else
        palette[n] = {3{COLOR_W'((n - 7) * 32)}};
    end
    palette[PALETTE_ENTRIES_MAX - 1] = palette[3];
    load_palette(PAIR_W'({$urandom, $urandom}));
    send_pixel(32'h000000FF);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00FFFFFF);
    send_pixel(32'h303030FF);
    send_pixel(32'h3030307F);
    send_pixel(32'hE0E0E0FF);
    send_pixel(32'hF0F0F0FF);
    send_pixel(32'hFF000080);
    send_pixel(32'h808080FF);
    send_pixel(32'h1F1F1F01);
    send_pixel(32'h0F0F0FFF);
    send_pixel(32'h7F00FFFF);
    run_random(400, -1, -1);

    // all ones, with zeros written to the unused indexes
    foreach (palette[n]) palette[n] = '1;
    load_palette('0);
    send_pixel(32'h000000FF);
    send_pixel(32'hFFFFFF00);
    run_random(100, -1, -1);

    foreach (palette[n]) palette[n] = RGB_W'($urandom);
    load_palette(PAIR_W'({$urandom, $urandom}));
    run_random(500, 150, -1);

    // tight cluster with repeats: many near and exact ties
    foreach (palette[n]) begin
      if (n > 0 && $urandom_range(3) == 0)
        palette[n] = palette[$urandom_range(n - 1)];
      else
        palette[n] = {COLOR_W'($urandom_range(8'h90, 8'h70)),
                      COLOR_W'($urandom_range(8'h90, 8'h70)),
                      COLOR_W'($urandom_range(8'h90, 8'h70))};
    end
    load_palette(PAIR_W'({$urandom, $urandom}));
    run_random(500, -1, 250);

    foreach (palette[n]) palette[n] = RGB_W'($urandom);
    load_palette('1);
    steady = 1'b1;
    run_random(500, -1, -1);

    drain();
    if (board.failures == 0 && board.expected_matches.size() == 0) begin
      $display("tb_nearest_palette_colour_quantizer OK");
    end else begin
      $display("tb_nearest_palette_colour_quantizer NOT OK");
    end
    $finish;
  end

endmodule
